/* rtl/core/cspa_pkg.sv */
`default_nettype none

package cspa_pkg;

	localparam int RefW    = 63;
	localparam int PeriodW = 30;
	localparam int AdjW    = 32;
	localparam int ErrW    = 31;
	localparam int IntW    = 32;
	localparam int DqW     = 64;
	localparam int HalfW   = DqW / 2;
	localparam int CntW    = $clog2(DqW);

	localparam logic [RefW-1:0]    SyncOffset  = RefW'(50000);
	localparam logic [PeriodW-1:0] PropDiv     = PeriodW'(100);
	localparam logic [PeriodW-1:0] IntDiv      = PeriodW'(20);
	localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(2000000);

	// reciprocals for the two constant divisions, exact for 32-bit magnitudes
	localparam logic [HalfW-1:0]   PropRecip   = HalfW'(32'h51EB851F);
	localparam int                 PropShift   = 37;
	localparam logic [HalfW-1:0]   IntRecip    = HalfW'(32'hCCCCCCCD);
	localparam int                 IntShift    = 36;

endpackage

`default_nettype wire

/* rtl/core/clock_sync_pi_adjust.sv */
// the result follows 64 remainder steps, then the fold, the two reciprocal
// multiplications and the finish; a new item is taken only in the idle state,
// once the last one has left the finish step; the remainder is a bit-per-cycle
// shift-subtract, and a stalled result holds the finish step and with it the input
// reset: arst_n clears the integrator to zero, the period to 2000000 ns
// and empties the output register
`default_nettype none

module clock_sync_pi_adjust (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [cspa_pkg::PeriodW-1:0]        cfg_wr_data,
	input  wire logic                                in_valid,
	output      logic                                in_stall,
	input  wire logic [cspa_pkg::RefW-1:0]           reference_time,
	output      logic                                out_valid,
	input  wire logic                                out_stall,
	output      logic signed [cspa_pkg::AdjW-1:0]    time_adjust,
	output      logic signed [cspa_pkg::ErrW-1:0]    phase_error
);
	import cspa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_FOLD,
		ST_PDIV,
		ST_IDIV,
		ST_FIN
	} state_t;

	state_t                     state_q;
	logic [PeriodW-1:0]         period_q;
	logic signed [IntW-1:0]     int_q;
	logic [DqW-1:0]             dq_q;
	logic [PeriodW-1:0]         rem_q;
	logic [CntW-1:0]            cnt_q;
	logic                       neg_q;
	logic signed [ErrW-1:0]     err_q;
	logic [HalfW-1:0]           qa_q;
	logic [HalfW-1:0]           qi_q;
	logic                       out_valid_q;
	logic signed [AdjW-1:0]     adj_q;
	logic signed [ErrW-1:0]     perr_q;

	logic [PeriodW-1:0]         p_eff;
	logic [PeriodW:0]           shifted;
	logic [PeriodW:0]           diff;
	logic                       ge;
	logic [PeriodW-1:0]         rem_n;
	logic                       ref_neg;
	logic [DqW-1:0]             ref_mag;
	logic signed [ErrW-1:0]     err_n;
	logic [HalfW-1:0]           err_mag;
	logic [HalfW-1:0]           int_mag;
	logic [HalfW-1:0]           mul_a;
	logic [HalfW-1:0]           mul_b;
	logic [DqW-1:0]             prod;
	logic [HalfW-1:0]           quo;
	logic [AdjW-1:0]            term_p;
	logic [AdjW-1:0]            term_i;
	logic                       in_xfer;
	logic                       out_xfer;

	assign p_eff    = (period_q == '0) ? PeriodW'(1) : period_q;
	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;

	// shift-subtract step of the remainder
	always_comb begin
		shifted = {rem_q, dq_q[DqW-1]};
		diff    = shifted - {1'b0, p_eff};
		ge      = (shifted >= {1'b0, p_eff});
		rem_n   = ge ? diff[PeriodW-1:0] : shifted[PeriodW-1:0];
	end

	always_comb begin
		ref_neg = (reference_time < SyncOffset);
		ref_mag = ref_neg ? DqW'(SyncOffset - reference_time)
			: DqW'(reference_time - SyncOffset);
	end

	// fold a remainder above half the period for a non-negative dividend, else apply the dividend's sign
	always_comb begin
		if (!neg_q && (rem_q > (p_eff >> 1)))
			err_n = ErrW'({1'b0, rem_q}) - ErrW'({1'b0, p_eff});
		else if (neg_q)
			err_n = -ErrW'({1'b0, rem_q});
		else
			err_n = ErrW'({1'b0, rem_q});
	end

	always_comb begin
		err_mag = err_q[ErrW-1] ? HalfW'(-err_q) : HalfW'(err_q);
		err_mag[HalfW-1] = 1'b0;
		int_mag = int_q[IntW-1] ? HalfW'(-int_q) : HalfW'(int_q);
		term_p  = err_q[ErrW-1] ? AdjW'(qa_q) : -AdjW'(qa_q);
		term_i  = int_q[IntW-1] ? AdjW'(qi_q) : -AdjW'(qi_q);
	end

	// one multiplier for both constant divisions, by reciprocal
	always_comb begin
		if (state_q == ST_PDIV) begin
			mul_a = err_mag;
			mul_b = PropRecip;
		end else begin
			mul_a = int_mag;
			mul_b = IntRecip;
		end
		prod = DqW'(mul_a) * DqW'(mul_b);
		quo  = (state_q == ST_PDIV) ? HalfW'(prod >> PropShift) : HalfW'(prod >> IntShift);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			period_q    <= PeriodReset;
			int_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				period_q <= cfg_wr_data;
			if (out_xfer && state_q != ST_FIN)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						dq_q    <= ref_mag;
						neg_q   <= ref_neg;
						rem_q   <= '0;
						cnt_q   <= CntW'(DqW - 1);
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					dq_q  <= {dq_q[DqW-2:0], ge};
					rem_q <= rem_n;
					cnt_q <= cnt_q - CntW'(1);
					if (cnt_q == '0)
						state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					err_q <= err_n;
					// sign integrator, saturating at the 32-bit limits
					if (err_n > 0 && int_q != {1'b0, {(IntW-1){1'b1}}})
						int_q <= int_q + IntW'(1);
					else if (err_n < 0 && int_q != {1'b1, {(IntW-1){1'b0}}})
						int_q <= int_q - IntW'(1);
					state_q <= ST_PDIV;
				end
				ST_PDIV: begin
					qa_q    <= quo;
					state_q <= ST_IDIV;
				end
				ST_IDIV: begin
					qi_q    <= quo;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						adj_q       <= term_p + term_i;
						perr_q      <= err_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign time_adjust = adj_q;
	assign phase_error = perr_q;

	a_int_step: assert property (@(posedge clk) disable iff (!arst_n)
		(int_q != $past(int_q)) |->
		((int_q - $past(int_q)) == IntW'(1) || (int_q - $past(int_q)) == {IntW{1'b1}}))
		else $error("integrator moved by more than one step");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD) |-> (rem_q < p_eff))
		else $error("partial remainder not below period");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_MOD))
		else $error("input transfer did not start the remainder");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
		else $error("result shown outside finish step");

endmodule

`default_nettype wire

/* tb/sv/clock_sync_pi_adjust_chk.sv */
`default_nettype none

module sync_adjust_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [cspa_pkg::PeriodW-1:0]       cfg_wr_data,
	input  wire logic                               in_valid,
	input  wire logic                               in_stall,
	input  wire logic [cspa_pkg::RefW-1:0]          reference_time,
	input  wire logic                               out_valid,
	input  wire logic                               out_stall,
	input  wire logic signed [cspa_pkg::AdjW-1:0]   time_adjust,
	input  wire logic signed [cspa_pkg::ErrW-1:0]   phase_error,
	output int                                      mismatches,
	output int                                      pending
);
	import cspa_pkg::*;

	localparam logic signed [IntW-1:0] IntMax = {1'b0, {(IntW-1){1'b1}}};
	localparam logic signed [IntW-1:0] IntMin = {1'b1, {(IntW-1){1'b0}}};

	typedef struct packed {
		logic signed [AdjW-1:0] adj;
		logic signed [ErrW-1:0] err;
	} adjust_t;

	adjust_t                expected_adjust_q[$];
	logic [PeriodW-1:0]     period_reg;
	logic signed [IntW-1:0] integ;

	// folded phase error, sign integrator step and the resulting correction
	function automatic adjust_t predict_adjust(input logic [RefW-1:0] ref_ns);
		longint  span;
		longint  phase;
		longint  corr;
		adjust_t r;
		span = (period_reg == '0) ? 64'sd1 : $signed({34'd0, period_reg});
		phase = $signed({1'b0, ref_ns}) - $signed({1'b0, SyncOffset});
		phase = phase % span;
		if (phase > span / 2)
			phase -= span;
		if (phase > 0 && integ != IntMax)
			integ++;
		else if (phase < 0 && integ != IntMin)
			integ--;
		corr = -(phase / $signed({34'd0, PropDiv}))
			- (longint'(integ) / $signed({34'd0, IntDiv}));
		r.adj = corr[AdjW-1:0];
		r.err = phase[ErrW-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		adjust_t exp_r;
		if (!arst_n) begin
			period_reg = PeriodReset;
			integ = '0;
			mismatches = 0;
			expected_adjust_q.delete();
		end else begin
			if (cfg_wr_en)
				period_reg = cfg_wr_data;
			// check the outgoing transfer before queueing a new one
			if (out_valid && !out_stall) begin
				if (expected_adjust_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result adj=%0d err=%0d",
						time_adjust, phase_error));
				end else begin
					exp_r = expected_adjust_q.pop_front();
					if (time_adjust !== exp_r.adj)
						report_mismatch($sformatf("time_adjust %0d, expected %0d",
							time_adjust, exp_r.adj));
					if (phase_error !== exp_r.err)
						report_mismatch($sformatf("phase_error %0d, expected %0d",
							phase_error, exp_r.err));
				end
			end
			if (in_valid && !in_stall)
				expected_adjust_q.push_back(predict_adjust(reference_time));
		end
		pending <= expected_adjust_q.size();
	end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none

module tb;
	import cspa_pkg::*;

	localparam int QuietLimit = 5000;
	localparam int PhaseItems = 170;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [PeriodW-1:0]     cfg_wr_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [RefW-1:0]        reference_time;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [AdjW-1:0] time_adjust;
	logic signed [ErrW-1:0] phase_error;
	int                     mismatches;
	int                     pending;
	int                     idle_pct;
	int                     stall_pct;
	int                     quiet_cycles;
	logic [PeriodW-1:0]     cur_period;

	always #6 clk = ~clk;

	clock_sync_pi_adjust uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.reference_time(reference_time),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.time_adjust   (time_adjust),
		.phase_error   (phase_error)
	);

	sync_adjust_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.reference_time(reference_time),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.time_adjust   (time_adjust),
		.phase_error   (phase_error),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// no transfer of any kind for too long means the block hung
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [RefW-1:0] rand_ref();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[RefW-1:0];
	endfunction

	// mostly reference times near the sync points of the running period
	function automatic logic [RefW-1:0] pick_ref_time(input logic [PeriodW-1:0] period);
		longint span;
		longint base;
		longint jit;
		longint v;
		int     kind;
		span = (period == '0) ? 64'sd1 : $signed({34'd0, period});
		kind = $urandom_range(99);
		if (kind < 55) begin
			base = longint'(rand_ref() >> 1);
			base = (base / span) * span + 50000;
			case ($urandom_range(5))
				0: jit = span / 2;
				1: jit = span / 2 + 1;
				2: jit = -(span / 2);
				3: jit = $signed({32'd0, $urandom}) % (span + 2) - span / 2 - 1;
				default: jit = longint'($urandom_range(4000)) - 2000;
			endcase
			v = base + jit;
			if (v < 0)
				v = -v;
			return v[RefW-1:0];
		end else if (kind < 70) begin
			return RefW'($urandom_range(120000));
		end else if (kind < 88) begin
			return rand_ref();
		end else begin
			case ($urandom_range(3))
				0: return '1;
				1: return '1 - RefW'($urandom_range(100000));
				2: return '0;
				default: return RefW'(50000);
			endcase
		end
	endfunction

	task automatic send_item(input logic [RefW-1:0] t);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			reference_time <= rand_ref();
			@(posedge clk);
		end
		in_valid <= 1'b1;
		reference_time <= t;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic set_period(input logic [PeriodW-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_period = v;
	endtask

	initial begin
		logic [RefW-1:0]    directed[13];
		logic [PeriodW-1:0] period_plan[9];
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		reference_time = '0;
		idle_pct = 0;
		stall_pct = 0;
		cur_period = PeriodReset;

		// reference before offset, zero error, exact half period and just past it
		directed = '{RefW'(0), RefW'(49999), RefW'(50000), RefW'(50001),
			RefW'(1050000), RefW'(1050001), RefW'(2049999), RefW'(2050000),
			'1, '1 - RefW'(1), {1'b1, {(RefW-1){1'b0}}},
			{1'b1, {(RefW/2){2'b01}}}, {1'b0, {(RefW/2){2'b01}}}};
		period_plan = '{PeriodW'(1000000000), PeriodW'(1), PeriodW'(0), '1,
			PeriodW'(250000), PeriodW'(3), PeriodW'(2000000), PeriodW'(0),
			PeriodW'(1000000)};
		period_plan[7] = PeriodW'($urandom_range(1000000000, 1));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i]);
		for (int n = 0; n < PhaseItems; n++)
			send_item(pick_ref_time(cur_period));

		foreach (period_plan[p]) begin
			set_period(period_plan[p]);
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 47; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 47; end
				default: begin idle_pct = 28; stall_pct = 28; end
			endcase
			for (int n = 0; n < PhaseItems; n++)
				send_item(pick_ref_time(cur_period));
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
